/* sv/csvt_pkg.sv */
package csvt_pkg;

  // Whitespace hold depth and the index and count widths that follow from it.
  localparam int unsigned HOLD_DEPTH = 16;
  localparam int unsigned HOLD_IW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned HOLD_CW    = $clog2(HOLD_DEPTH + 1);

  // Command queue between the classifier and the emitter.
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [15:0] DELIM_RESET = 16'd44;
  localparam logic [15:0] UNIT_QUOTE  = 16'h0022;
  localparam logic [15:0] UNIT_LF     = 16'h000A;
  localparam logic [15:0] UNIT_CR     = 16'h000D;

  typedef enum logic [1:0] {
    TOK_CONTENT    = 2'd0,
    TOK_FIELD_END  = 2'd1,
    TOK_RECORD_END = 2'd2
  } token_kind_e;

  typedef enum logic [1:0] {
    CMD_HOLD       = 2'd0,
    CMD_CONTENT    = 2'd1,
    CMD_FIELD_END  = 2'd2,
    CMD_RECORD_END = 2'd3
  } cmd_kind_e;

  typedef enum logic {
    PH_FIRST  = 1'b0,
    PH_SECOND = 1'b1
  } rec_phase_e;

  typedef struct packed {
    logic [15:0] text_unit;
    logic        end_of_content;
  } in_item_t;

  typedef struct packed {
    token_kind_e token_kind;
    logic [15:0] content_unit;
    logic        hold_overflow;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] unit;
  } cmd_t;

  function automatic logic is_space(input logic [15:0] u);
    logic sp;
    sp = ((u >= 16'h0009) && (u <= 16'h000D)) || (u == 16'h0020) || (u == 16'h0085) ||
         (u == 16'h00A0) || (u == 16'h1680) || ((u >= 16'h2000) && (u <= 16'h200A)) ||
         (u == 16'h2028) || (u == 16'h2029) || (u == 16'h202F) || (u == 16'h205F) ||
         (u == 16'h3000);
    return sp;
  endfunction

endpackage

/* sv/csv_field_tokenizer_top.sv */
// Path: an accepted item's command is registered in the command queue, and its result then
// in the output register. Throughput: one item per cycle while each item gives at most one
// result and the queue is not full; the emitter gives one result per cycle while results are
// popped, so an item that flushes n held units gives n + 1 results, and a record end gives
// two. A four-entry command queue absorbs the difference.
// Reset: clears parser flags, queue, hold count and output; delimiter returns to comma.
module csv_field_tokenizer_top import csvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output result_t     res_o,
  input  logic        delim_we_i,
  input  logic [15:0] delim_wdata_i
);

  logic item_acc;
  logic cmd_push, cmdq_full, cmd_valid, cmd_pop, res_valid;
  cmd_t cmd_wdata, cmd_head;

  assign item_acc = push && !full;
  assign full     = cmdq_full;
  assign empty    = !res_valid;

  csvt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delim_we_i    (delim_we_i),
    .delim_wdata_i (delim_wdata_i),
    .item_valid_i  (item_acc),
    .item_i        (in_item_i),
    .cmd_valid_o   (cmd_push),
    .cmd_o         (cmd_wdata)
  );

  csvt_cmd_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .pop_i   (cmd_pop),
    .full_o  (cmdq_full),
    .valid_o (cmd_valid),
    .rdata_o (cmd_head)
  );

  csvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res_o),
    .res_pop_i   (pop)
  );

  // The classifier only produces a command for an accepted transaction, so it never overruns.
  a_no_cmd_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmdq_full)
    else $error("command written into a full queue");

  a_marks_carry_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.token_kind != TOK_CONTENT) |->
      (res_o.content_unit == '0 && !res_o.hold_overflow))
    else $error("field or record mark carries a unit or overflow flag");

  a_overflow_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.hold_overflow) |->
      (res_o.token_kind == TOK_CONTENT && res_o.last_of_run))
    else $error("overflowed unit is not the only result of its transaction");

  a_record_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.token_kind == TOK_RECORD_END) |-> res_o.last_of_run)
    else $error("record end is not the last result of its transaction");

endmodule

/* sv/csvt_front.sv */
module csvt_front import csvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        delim_we_i,
  input  logic [15:0] delim_wdata_i,
  input  logic        item_valid_i,
  input  in_item_t    item_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o
);

  logic [15:0] delim_q;
  logic quoted_q, quoted_d;
  logic qseen_q, qseen_d;
  logic cr_q, cr_d;
  logic fhc_q, fhc_d;
  logic rpf_q, rpf_d;

  logic [15:0] u;
  logic take_unq, take_cont, field_end, rec_end;

  assign u = item_i.text_unit;

  always_comb begin
    quoted_d    = quoted_q;
    qseen_d     = qseen_q;
    cr_d        = cr_q;
    fhc_d       = fhc_q;
    rpf_d       = rpf_q;
    take_unq    = 1'b0;
    take_cont   = 1'b0;
    field_end   = 1'b0;
    rec_end     = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CMD_CONTENT;
    cmd_o.unit  = u;

    if (item_valid_i) begin
      if (item_i.end_of_content) begin
        rec_end  = 1'b1;
        quoted_d = 1'b0;
        qseen_d  = 1'b0;
        cr_d     = 1'b0;
      end else if (qseen_q) begin
        qseen_d = 1'b0;
        if (u == UNIT_QUOTE) begin
          take_cont = 1'b1;
        end else begin
          quoted_d = 1'b0;
          take_unq = 1'b1;
        end
      end else if (cr_q) begin
        // The LF of a CRLF pair has already been handled by the CR.
        cr_d = 1'b0;
        if (u != UNIT_LF) begin
          take_unq = 1'b1;
        end
      end else if (quoted_q) begin
        if (u == UNIT_QUOTE) begin
          qseen_d = 1'b1;
        end else begin
          take_cont = 1'b1;
        end
      end else begin
        take_unq = 1'b1;
      end
    end

    if (take_unq) begin
      if (u == UNIT_QUOTE) begin
        quoted_d = 1'b1;
      end else if (u == delim_q) begin
        field_end = 1'b1;
      end else if (u == UNIT_LF) begin
        rec_end = 1'b1;
      end else if (u == UNIT_CR) begin
        rec_end = 1'b1;
        cr_d    = 1'b1;
      end else begin
        take_cont = 1'b1;
      end
    end

    if (take_cont) begin
      if (is_space(u)) begin
        // Leading whitespace is dropped; later whitespace goes to the hold.
        if (fhc_q) begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_HOLD;
        end
      end else begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = CMD_CONTENT;
        fhc_d       = 1'b1;
      end
    end

    if (field_end) begin
      cmd_valid_o = 1'b1;
      cmd_o.kind  = CMD_FIELD_END;
      fhc_d       = 1'b0;
      rpf_d       = 1'b1;
    end

    if (rec_end) begin
      // A record of one empty field emits nothing, and its hold is already empty.
      if (rpf_q || fhc_q) begin
        cmd_valid_o = 1'b1;
        cmd_o.kind  = CMD_RECORD_END;
      end
      fhc_d = 1'b0;
      rpf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= DELIM_RESET;
      quoted_q <= 1'b0;
      qseen_q  <= 1'b0;
      cr_q     <= 1'b0;
      fhc_q    <= 1'b0;
      rpf_q    <= 1'b0;
    end else begin
      if (delim_we_i) begin
        delim_q <= delim_wdata_i;
      end
      quoted_q <= quoted_d;
      qseen_q  <= qseen_d;
      cr_q     <= cr_d;
      fhc_q    <= fhc_d;
      rpf_q    <= rpf_d;
    end
  end

endmodule

/* sv/csvt_cmd_fifo.sv */
module csvt_cmd_fifo import csvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t rdata_o
);

  cmd_t                 entries_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CW-1:0]   count_q;
  logic                 do_push, do_pop;

  function automatic logic [CMDQ_AW-1:0] ptr_inc(input logic [CMDQ_AW-1:0] p);
    logic [CMDQ_AW-1:0] n;
    if (p == CMDQ_AW'(CMDQ_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + CMDQ_AW'(1);
    end
    return n;
  endfunction

  assign full_o  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CMDQ_CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CMDQ_CW'(1);
      end
    end
  end

endmodule

/* sv/csvt_back.sv */
module csvt_back import csvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_pop_i
);

  logic [15:0]        hold_regs_q [HOLD_DEPTH];
  logic [HOLD_IW-1:0] head_q, head_d;
  logic [HOLD_CW-1:0] cnt_q, cnt_d;
  logic [HOLD_IW-1:0] tail;
  logic [HOLD_CW:0]   tail_sum;
  logic               hold_we;
  rec_phase_e         phase_q, phase_d;

  logic    out_valid_q, out_valid_d;
  result_t out_q, res_d;
  logic    emit, out_ok;

  assign tail_sum = (HOLD_CW + 1)'(head_q) + (HOLD_CW + 1)'(cnt_q);
  assign tail     = (tail_sum >= (HOLD_CW + 1)'(HOLD_DEPTH))
                  ? HOLD_IW'(tail_sum - (HOLD_CW + 1)'(HOLD_DEPTH))
                  : HOLD_IW'(tail_sum);

  function automatic logic [HOLD_IW-1:0] idx_inc(input logic [HOLD_IW-1:0] p);
    logic [HOLD_IW-1:0] n;
    if (p == HOLD_IW'(HOLD_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + HOLD_IW'(1);
    end
    return n;
  endfunction

  assign out_ok = !out_valid_q || res_pop_i;

  always_comb begin
    head_d              = head_q;
    cnt_d               = cnt_q;
    phase_d             = phase_q;
    hold_we             = 1'b0;
    cmd_pop_o           = 1'b0;
    emit                = 1'b0;
    res_d.token_kind    = TOK_CONTENT;
    res_d.content_unit  = '0;
    res_d.hold_overflow = 1'b0;
    res_d.last_of_run   = 1'b0;

    if (cmd_valid_i && out_ok) begin
      unique case (cmd_i.kind)
        CMD_HOLD: begin
          cmd_pop_o = 1'b1;
          hold_we   = 1'b1;
          if (cnt_q == HOLD_CW'(HOLD_DEPTH)) begin
            // Hold full: the oldest unit leaves flagged and the new one takes its slot.
            emit                = 1'b1;
            res_d.content_unit  = hold_regs_q[head_q];
            res_d.hold_overflow = 1'b1;
            res_d.last_of_run   = 1'b1;
            head_d              = idx_inc(head_q);
          end else begin
            cnt_d = cnt_q + HOLD_CW'(1);
          end
        end
        CMD_CONTENT: begin
          emit = 1'b1;
          if (cnt_q != '0) begin
            res_d.content_unit = hold_regs_q[head_q];
            head_d             = idx_inc(head_q);
            cnt_d              = cnt_q - HOLD_CW'(1);
          end else begin
            res_d.content_unit = cmd_i.unit;
            res_d.last_of_run  = 1'b1;
            cmd_pop_o          = 1'b1;
          end
        end
        CMD_FIELD_END: begin
          emit              = 1'b1;
          res_d.token_kind  = TOK_FIELD_END;
          res_d.last_of_run = 1'b1;
          cnt_d             = '0;
          cmd_pop_o         = 1'b1;
        end
        CMD_RECORD_END: begin
          emit = 1'b1;
          unique case (phase_q)
            PH_FIRST: begin
              res_d.token_kind = TOK_FIELD_END;
              phase_d          = PH_SECOND;
            end
            PH_SECOND: begin
              res_d.token_kind  = TOK_RECORD_END;
              res_d.last_of_run = 1'b1;
              cnt_d             = '0;
              cmd_pop_o         = 1'b1;
              phase_d           = PH_FIRST;
            end
            default: begin
              phase_d = PH_FIRST;
            end
          endcase
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      hold_regs_q[tail] <= cmd_i.unit;
    end
    if (emit) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
